### design/genotype_variant_qc_filter_core_defines.svh
// assertion macros shared by the filter core
`ifndef GENOTYPE_VARIANT_QC_FILTER_CORE_DEFINES_SVH
`define GENOTYPE_VARIANT_QC_FILTER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define GVQC_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gvqc check failed");

// next-cycle implication, sampled on clk, off during reset
`define GVQC_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gvqc check failed");

`endif

### design/gvqc_pkg.sv
package gvqc_pkg;

    localparam int DOSE_W     = 8;
    localparam int CNT_W      = 21;
    localparam int SUM_W      = 28;
    localparam int MAC_W      = 22;
    localparam int TOT_W      = 22;
    localparam int FRAC_BITS  = 16;
    localparam int MAF_W      = 16;
    localparam int MISS_W     = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 22;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 72;

    localparam int MAX_INDIVIDUALS = 1048576;

    localparam logic [TOT_W-1:0] TOT_LIMIT = TOT_W'(MAX_INDIVIDUALS);
    localparam logic [CNT_W-1:0] CNT_TOP   = '1;
    localparam logic [SUM_W-1:0] SUM_TOP   = '1;
    localparam logic [MAC_W-1:0] MAC_TOP   = 22'd2097152;
    localparam logic [MAF_W-1:0] HALF_FRAC = 16'd32768;

    localparam logic [DOSE_W-1:0] MISSING_CODE_RST = 8'd3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MISSING_CODE  = 3'd0,
        REG_MAF_MIN       = 3'd1,
        REG_MAF_MAX       = 3'd2,
        REG_MAC_MIN       = 3'd3,
        REG_MAC_MAX       = 3'd4,
        REG_MISS_RATE_MAX = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        REASON_KEEP    = 2'd0,
        REASON_FREQ    = 2'd1,
        REASON_COUNT   = 2'd2,
        REASON_MISSING = 2'd3
    } reason_t;

    typedef struct packed {
        logic [DOSE_W-1:0] missing_code;
        logic [MAF_W-1:0]  maf_min;
        logic [MAF_W-1:0]  maf_max;
        logic [MAC_W-1:0]  mac_min;
        logic [MAC_W-1:0]  mac_max;
        logic [MISS_W-1:0] miss_rate_max;
    } cfg_t;

    typedef struct packed {
        logic [CNT_W-1:0] called;
        logic [CNT_W-1:0] missing;
        logic [SUM_W-1:0] dsum;
    } counts_t;

    typedef struct packed {
        logic             keep;
        reason_t          fail_reason;
        logic [MAC_W-1:0] minor_count;
        logic [CNT_W-1:0] called_count;
        logic [CNT_W-1:0] missing_count;
    } result_t;

endpackage

### design/genotype_variant_qc_filter_core.sv
// variant quality filter core
//
// s_axis carries one dosage per item (tdata[7:0]); tlast marks the final
// individual of a variant. m_axis carries one decision item per variant.
// cfg writes the six threshold registers by index; take it only while idle.
//
// an input item is taken every cycle while s_axis_tready is high. the dosage
// goes straight into the running counts; on the last item the updated
// counts are latched, the checks are evaluated combinationally from that
// latch and land in the output register, from which m_axis is driven.
// the rate is one item per clock while m_axis keeps up, bounded by the
// single count update and the check stage (three multipliers feeding compares).
//
// reset clears the counts, both stage valids and loads the register
// defaults (missing code 3, all checks off). when m_axis stalls the output
// register holds its item and one more finished variant waits in the count
// latch; from then on s_axis_tready stays low for every item, last or not,
// until the output register is taken and the latch can move on.
`include "genotype_variant_qc_filter_core_defines.svh"

module genotype_variant_qc_filter_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [gvqc_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // dosage
    input  logic                               s_axis_tlast,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // keep, fail_reason, minor_count, called_count, missing_count, zero pad
    output logic [gvqc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [gvqc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gvqc_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int PAD_W = gvqc_pkg::OUT_DATA_W - $bits(gvqc_pkg::result_t);

    gvqc_pkg::cfg_t    cfg;
    gvqc_pkg::counts_t fin_counts;
    gvqc_pkg::result_t result;
    gvqc_pkg::result_t out_res_reg;
    logic              fin_valid;
    logic              fin_take;
    logic              item_accept;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [gvqc_pkg::TOT_W-1:0] fin_total;

    gvqc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    gvqc_accum u_accum (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_accept  (item_accept),
        .dosage       (s_axis_tdata[gvqc_pkg::DOSE_W-1:0]),
        .last         (s_axis_tlast),
        .missing_code (cfg.missing_code),
        .fin_take     (fin_take),
        .fin_valid    (fin_valid),
        .fin_counts   (fin_counts)
    );

    gvqc_decide u_decide (
        .counts (fin_counts),
        .cfg    (cfg),
        .result (result)
    );

    assign fin_take      = fin_valid && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !fin_valid || fin_take;
    assign item_accept   = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fin_take)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (fin_take)
            out_res_reg <= result;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}},
                            out_res_reg.missing_count,
                            out_res_reg.called_count,
                            out_res_reg.minor_count,
                            out_res_reg.fail_reason,
                            out_res_reg.keep};

    assign fin_total = gvqc_pkg::TOT_W'(fin_counts.called)
                     + gvqc_pkg::TOT_W'(fin_counts.missing);

    `GVQC_ASSERT_NXT(a_last_latched, item_accept && s_axis_tlast, fin_valid)
    `GVQC_ASSERT_IMP(a_total_bounded, fin_valid, fin_total <= gvqc_pkg::TOT_LIMIT)
    `GVQC_ASSERT_IMP(a_keep_matches, out_valid_reg,
                     out_res_reg.keep == (out_res_reg.fail_reason == gvqc_pkg::REASON_KEEP))
    `GVQC_ASSERT_IMP(a_freq_needs_calls,
                     out_valid_reg && (out_res_reg.fail_reason == gvqc_pkg::REASON_FREQ),
                     out_res_reg.called_count != '0)

endmodule

### design/gvqc_cfg.sv
module gvqc_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [gvqc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [gvqc_pkg::CFG_DATA_W-1:0]  cfg_data,
    output gvqc_pkg::cfg_t                   cfg
);

    gvqc_pkg::cfg_t cfg_reg;
    gvqc_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (gvqc_pkg::cfg_reg_t'(cfg_index))
                gvqc_pkg::REG_MISSING_CODE:
                    cfg_next.missing_code  = cfg_data[gvqc_pkg::DOSE_W-1:0];
                gvqc_pkg::REG_MAF_MIN:
                    cfg_next.maf_min       = cfg_data[gvqc_pkg::MAF_W-1:0];
                gvqc_pkg::REG_MAF_MAX:
                    cfg_next.maf_max       = cfg_data[gvqc_pkg::MAF_W-1:0];
                gvqc_pkg::REG_MAC_MIN:
                    cfg_next.mac_min       = cfg_data[gvqc_pkg::MAC_W-1:0];
                gvqc_pkg::REG_MAC_MAX:
                    cfg_next.mac_max       = cfg_data[gvqc_pkg::MAC_W-1:0];
                gvqc_pkg::REG_MISS_RATE_MAX:
                    cfg_next.miss_rate_max = cfg_data[gvqc_pkg::MISS_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.missing_code  <= gvqc_pkg::MISSING_CODE_RST;
            cfg_reg.maf_min       <= '0;
            cfg_reg.maf_max       <= gvqc_pkg::HALF_FRAC;
            cfg_reg.mac_min       <= '0;
            cfg_reg.mac_max       <= gvqc_pkg::MAC_TOP;
            cfg_reg.miss_rate_max <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### design/gvqc_accum.sv
module gvqc_accum (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_accept,
    input  logic [gvqc_pkg::DOSE_W-1:0]   dosage,
    input  logic                          last,
    input  logic [gvqc_pkg::DOSE_W-1:0]   missing_code,
    input  logic                          fin_take,
    output logic                          fin_valid,
    output gvqc_pkg::counts_t             fin_counts
);

    gvqc_pkg::counts_t acc_reg;
    gvqc_pkg::counts_t acc_next;
    gvqc_pkg::counts_t fin_reg;
    logic              fin_valid_reg;
    logic              fin_valid_next;

    logic [gvqc_pkg::TOT_W-1:0] total;
    logic                       room;
    logic                       is_missing;
    logic [gvqc_pkg::SUM_W:0]   sum_wide;

    assign total      = gvqc_pkg::TOT_W'(acc_reg.called) + gvqc_pkg::TOT_W'(acc_reg.missing);
    assign room       = total < gvqc_pkg::TOT_LIMIT;
    assign is_missing = dosage == missing_code;
    assign sum_wide   = {1'b0, acc_reg.dsum} + (gvqc_pkg::SUM_W + 1)'(dosage);

    always_comb
    begin
        acc_next = acc_reg;
        // past the individual limit the dosage is dropped
        if (room)
        begin
            if (is_missing)
            begin
                if (acc_reg.missing != gvqc_pkg::CNT_TOP)
                    acc_next.missing = acc_reg.missing + 1'b1;
            end
            else
            begin
                if (acc_reg.called != gvqc_pkg::CNT_TOP)
                    acc_next.called = acc_reg.called + 1'b1;
                acc_next.dsum = sum_wide[gvqc_pkg::SUM_W] ? gvqc_pkg::SUM_TOP
                                                          : sum_wide[gvqc_pkg::SUM_W-1:0];
            end
        end
    end

    always_comb
    begin
        fin_valid_next = fin_valid_reg;
        if (item_accept && last)
            fin_valid_next = 1'b1;
        else if (fin_take)
            fin_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            fin_valid_reg <= 1'b0;
        end
        else
        begin
            fin_valid_reg <= fin_valid_next;
            if (item_accept)
                acc_reg <= last ? '0 : acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && last)
            fin_reg <= acc_next;
    end

    assign fin_valid  = fin_valid_reg;
    assign fin_counts = fin_reg;

endmodule

### design/gvqc_decide.sv
module gvqc_decide (
    input  gvqc_pkg::counts_t  counts,
    input  gvqc_pkg::cfg_t     cfg,
    output gvqc_pkg::result_t  result
);

    localparam int LHS_W  = gvqc_pkg::SUM_W + gvqc_pkg::FRAC_BITS;
    localparam int PMAF_W = gvqc_pkg::MAF_W + gvqc_pkg::MAC_W;
    localparam int MLHS_W = gvqc_pkg::CNT_W + gvqc_pkg::FRAC_BITS;
    localparam int PMIS_W = gvqc_pkg::MISS_W + gvqc_pkg::TOT_W;

    logic [gvqc_pkg::MAC_W-1:0] twoc;
    logic [gvqc_pkg::SUM_W-1:0] twoc_w;
    logic                       over;
    logic [gvqc_pkg::MAC_W-1:0] diff;
    logic [gvqc_pkg::MAC_W-1:0] sum_lo;
    logic [gvqc_pkg::MAC_W-1:0] mac;
    logic [gvqc_pkg::SUM_W-1:0] mf;
    logic [LHS_W-1:0]           maf_lhs;
    logic [PMAF_W-1:0]          maf_lo;
    logic [PMAF_W-1:0]          maf_hi;
    logic [gvqc_pkg::TOT_W-1:0] total;
    logic [MLHS_W-1:0]          miss_lhs;
    logic [PMIS_W-1:0]          miss_rhs;
    logic                       maf_en;
    logic                       mac_en;
    logic                       miss_en;
    logic                       maf_fail;
    logic                       mac_fail;
    logic                       miss_fail;
    gvqc_pkg::reason_t          reason;

    assign twoc   = {counts.called, 1'b0};
    assign twoc_w = gvqc_pkg::SUM_W'(twoc);
    assign over   = counts.dsum > twoc_w;
    assign sum_lo = counts.dsum[gvqc_pkg::MAC_W-1:0];
    assign diff   = twoc - sum_lo;
    assign mac    = over ? '0 : ((sum_lo < diff) ? sum_lo : diff);
    // with a sum above two per call the frequency uses the excess
    assign mf     = over ? (counts.dsum - twoc_w) : gvqc_pkg::SUM_W'(mac);

    assign maf_lhs = {mf, {gvqc_pkg::FRAC_BITS{1'b0}}};
    assign maf_lo  = cfg.maf_min * twoc;
    assign maf_hi  = cfg.maf_max * twoc;

    assign total    = gvqc_pkg::TOT_W'(counts.called) + gvqc_pkg::TOT_W'(counts.missing);
    assign miss_lhs = {counts.missing, {gvqc_pkg::FRAC_BITS{1'b0}}};
    assign miss_rhs = cfg.miss_rate_max * total;

    assign maf_en  = ((cfg.maf_min != '0) || (cfg.maf_max < gvqc_pkg::HALF_FRAC))
                     && (counts.called != '0);
    assign mac_en  = (cfg.mac_min != '0) || (cfg.mac_max != gvqc_pkg::MAC_TOP);
    assign miss_en = cfg.miss_rate_max != '0;

    assign maf_fail  = (maf_lhs < LHS_W'(maf_lo)) || (maf_lhs > LHS_W'(maf_hi));
    assign mac_fail  = (mac < cfg.mac_min) || (mac > cfg.mac_max);
    assign miss_fail = PMIS_W'(miss_lhs) > miss_rhs;

    always_comb
    begin
        priority if (maf_en && maf_fail)
            reason = gvqc_pkg::REASON_FREQ;
        else if (mac_en && mac_fail)
            reason = gvqc_pkg::REASON_COUNT;
        else if (miss_en && miss_fail)
            reason = gvqc_pkg::REASON_MISSING;
        else
            reason = gvqc_pkg::REASON_KEEP;
    end

    assign result.keep          = reason == gvqc_pkg::REASON_KEEP;
    assign result.fail_reason   = reason;
    assign result.minor_count   = mac;
    assign result.called_count  = counts.called;
    assign result.missing_count = counts.missing;

endmodule

### sim/tb_genotype_variant_qc_filter_core.sv
module tb_genotype_variant_qc_filter_core;

    import gvqc_pkg::*;

    typedef struct packed {
        logic [DOSE_W-1:0] dose;
        logic              last;
    } dose_item_t;

    // keeps its own copy of the thresholds and running counts, and lines up
    // the decision expected for every variant
    class variant_decision_board;
        cfg_t              cfg;
        logic [CNT_W-1:0]  called_n;
        logic [CNT_W-1:0]  missing_n;
        logic [SUM_W-1:0]  dose_sum;
        result_t           decisions_due[$];
        int                mismatches;

        function new();
            cfg.missing_code  = MISSING_CODE_RST;
            cfg.maf_min       = '0;
            cfg.maf_max       = HALF_FRAC;
            cfg.mac_min       = '0;
            cfg.mac_max       = MAC_TOP;
            cfg.miss_rate_max = '0;
            called_n   = '0;
            missing_n  = '0;
            dose_sum   = '0;
            mismatches = 0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_MISSING_CODE:  cfg.missing_code  = v[DOSE_W-1:0];
                REG_MAF_MIN:       cfg.maf_min       = v[MAF_W-1:0];
                REG_MAF_MAX:       cfg.maf_max       = v[MAF_W-1:0];
                REG_MAC_MIN:       cfg.mac_min       = v[MAC_W-1:0];
                REG_MAC_MAX:       cfg.mac_max       = v[MAC_W-1:0];
                REG_MISS_RATE_MAX: cfg.miss_rate_max = v[MISS_W-1:0];
                default: ;
            endcase
        endfunction

        // called for every accepted dosage item
        function void absorb_dosage(logic [DOSE_W-1:0] d, logic last);
            longint unsigned c, s, miss, twoc, mac, mf, tot;
            reason_t why;
            result_t r;
            if (64'(called_n) + 64'(missing_n) < 64'(MAX_INDIVIDUALS))
            begin
                if (d == cfg.missing_code)
                begin
                    if (missing_n != CNT_TOP)
                        missing_n = missing_n + 1'b1;
                end
                else
                begin
                    if (called_n != CNT_TOP)
                        called_n = called_n + 1'b1;
                    s = 64'(dose_sum) + 64'(d);
                    dose_sum = (s > 64'(SUM_TOP)) ? SUM_TOP : s[SUM_W-1:0];
                end
            end
            if (!last)
                return;

            c    = 64'(called_n);
            s    = 64'(dose_sum);
            miss = 64'(missing_n);
            twoc = 2 * c;
            // a sum above 2*called gives a zero count but |2c - s| for the frequency
            if (s <= twoc)
            begin
                mac = (s < twoc - s) ? s : twoc - s;
                mf  = mac;
            end
            else
            begin
                mac = 0;
                mf  = s - twoc;
            end

            why = REASON_KEEP;
            if ((cfg.maf_min != 0 || cfg.maf_max < HALF_FRAC) && c != 0)
            begin
                if ((mf << FRAC_BITS) < 64'(cfg.maf_min) * twoc ||
                    (mf << FRAC_BITS) > 64'(cfg.maf_max) * twoc)
                    why = REASON_FREQ;
            end
            if (why == REASON_KEEP && (cfg.mac_min != 0 || cfg.mac_max != MAC_TOP))
            begin
                if (mac < 64'(cfg.mac_min) || mac > 64'(cfg.mac_max))
                    why = REASON_COUNT;
            end
            if (why == REASON_KEEP && cfg.miss_rate_max != 0)
            begin
                tot = c + miss;
                if ((miss << FRAC_BITS) > 64'(cfg.miss_rate_max) * tot)
                    why = REASON_MISSING;
            end

            r.keep          = (why == REASON_KEEP);
            r.fail_reason   = why;
            r.minor_count   = mac[MAC_W-1:0];
            r.called_count  = called_n;
            r.missing_count = missing_n;
            decisions_due.push_back(r);
            called_n  = '0;
            missing_n = '0;
            dose_sum  = '0;
        endfunction

        function void match_decision(logic [OUT_DATA_W-1:0] t);
            result_t got, want;
            got.keep          = t[0];
            got.fail_reason   = reason_t'(t[2:1]);
            got.minor_count   = t[3 +: MAC_W];
            got.called_count  = t[3 + MAC_W +: CNT_W];
            got.missing_count = t[3 + MAC_W + CNT_W +: CNT_W];
            if (decisions_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("decision item with none pending: %h", t);
                return;
            end
            want = decisions_due.pop_front();
            if (got.keep !== want.keep || got.fail_reason !== want.fail_reason ||
                got.minor_count !== want.minor_count ||
                got.called_count !== want.called_count ||
                got.missing_count !== want.missing_count)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"decision mismatch: exp keep=%0d why=%0d mac=%0d called=%0d",
                              " miss=%0d, got keep=%0d why=%0d mac=%0d called=%0d miss=%0d"},
                             want.keep, want.fail_reason, want.minor_count,
                             want.called_count, want.missing_count,
                             got.keep, got.fail_reason, got.minor_count,
                             got.called_count, got.missing_count);
            end
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_DATA_W-1:0]      s_axis_tdata = '0;   // dosage
    logic                      s_axis_tlast = 1'b0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    // keep, fail_reason, minor_count, called_count, missing_count, zero pad
    logic [OUT_DATA_W-1:0]     m_axis_tdata;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_DATA_W-1:0]     cfg_data = '0;

    variant_decision_board sb;
    dose_item_t            stim_q[$];
    int                    long_hold = 0;

    genotype_variant_qc_filter_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // handshakes are sampled at the falling edge, where everything is settled
    always @(negedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.match_decision(m_axis_tdata);
    end

    // receiver: switches between random stall patterns
    initial
    begin : rx_side
        int mode;
        int mode_left;
        mode = 0;
        mode_left = 0;
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                long_hold--;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 80);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;
                    1:       m_axis_tready <= 1'($urandom_range(0, 1));
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                    default: m_axis_tready <= (mode_left % 4 != 0);
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #(64'd4_000_000);
        $display("Verification failed");
        $finish;
    end

    task automatic drive_item(logic [DOSE_W-1:0] d, logic last);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= last;
        do @(negedge clk); while (!s_axis_tready);
        @(posedge clk);
        sb.absorb_dosage(d, last);
    endtask

    task automatic play_stim();
        dose_item_t it;
        int burst_left;
        int gap;
        burst_left = $urandom_range(1, 40);
        while (stim_q.size() != 0)
        begin
            it = stim_q.pop_front();
            drive_item(it.dose, it.last);
            burst_left--;
            if (burst_left == 0)
            begin
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                burst_left = $urandom_range(1, 40);
                if (gap != 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every pending decision, then let the check stage settle
    task automatic drain();
        while (sb.decisions_due.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        sb.write_reg(idx, v);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_settings(logic [DOSE_W-1:0] mcode, logic [MAF_W-1:0] fmin,
                                 logic [MAF_W-1:0] fmax, logic [MAC_W-1:0] cmin,
                                 logic [MAC_W-1:0] cmax, logic [MISS_W-1:0] mrate);
        set_reg(REG_MISSING_CODE, CFG_DATA_W'(mcode));
        set_reg(REG_MAF_MIN, CFG_DATA_W'(fmin));
        set_reg(REG_MAF_MAX, CFG_DATA_W'(fmax));
        set_reg(REG_MAC_MIN, CFG_DATA_W'(cmin));
        set_reg(REG_MAC_MAX, CFG_DATA_W'(cmax));
        set_reg(REG_MISS_RATE_MAX, CFG_DATA_W'(mrate));
    endtask

    task automatic random_settings(output logic [DOSE_W-1:0] mcode);
        case ($urandom_range(0, 3))
            0:       mcode = MISSING_CODE_RST;
            1:       mcode = 8'($urandom_range(0, 2));
            default: mcode = 8'($urandom_range(0, 255));
        endcase
        load_settings(mcode,
                      ($urandom_range(0, 2) == 0) ? 16'd0 : 16'($urandom_range(0, 16384)),
                      ($urandom_range(0, 2) == 0) ? HALF_FRAC
                                                  : 16'($urandom_range(8192, 65535)),
                      22'($urandom_range(0, 4)),
                      ($urandom_range(0, 2) == 0) ? MAC_TOP : 22'($urandom_range(2, 24)),
                      ($urandom_range(0, 1) == 0) ? 17'd0 : 17'($urandom_range(1, 65536)));
    endtask

    // short variants mostly, with all-missing, heavy-missing and raw-byte ones mixed in
    task automatic queue_variants(int n_items, logic [DOSE_W-1:0] mcode);
        int total;
        int len;
        int flavor;
        logic [DOSE_W-1:0] d;
        total = 0;
        while (total < n_items)
        begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 60) : $urandom_range(1, 16);
            flavor = $urandom_range(0, 9);
            for (int k = 0; k < len; k++)
            begin
                case (flavor)
                    0: d = mcode;
                    1: d = ($urandom_range(0, 1) == 0) ? mcode : 8'($urandom_range(0, 2));
                    2: d = 8'($urandom_range(0, 255));
                    default:
                        if ($urandom_range(0, 7) == 0)
                            d = mcode;
                        else if ($urandom_range(0, 15) == 0)
                            d = 8'($urandom_range(0, 255));
                        else
                            d = 8'($urandom_range(0, 2));
                endcase
                stim_q.push_back('{d, (k == len - 1)});
            end
            total += len;
        end
    endtask

    task automatic add_item(logic [DOSE_W-1:0] d, logic last);
        stim_q.push_back('{d, last});
    endtask

    initial
    begin : stimulus
        logic [DOSE_W-1:0] mcode;
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default thresholds: every check off
        add_item(8'd0, 1'b0);
        add_item(8'd1, 1'b0);
        add_item(8'd2, 1'b0);
        add_item(8'd3, 1'b0);
        add_item(8'd2, 1'b1);
        add_item(8'd3, 1'b0);     // no calls at all
        add_item(8'd3, 1'b1);
        add_item(8'd255, 1'b1);   // dosage above two, not missing
        add_item(8'd0, 1'b1);
        play_stim();
        drain();

        // frequency floor at 1/8, count floor 2, full missing rate allowed
        load_settings(8'd255, 16'h2000, 16'hFFFF, 22'd2, 22'h3FFFFF, 17'h10000);
        add_item(8'd1, 1'b0);
        add_item(8'd0, 1'b0);
        add_item(8'd0, 1'b0);
        add_item(8'd0, 1'b1);
        add_item(8'd255, 1'b0);
        add_item(8'd255, 1'b1);
        add_item(8'd2, 1'b0);
        add_item(8'd2, 1'b0);
        add_item(8'd2, 1'b0);
        add_item(8'd0, 1'b1);
        play_stim();
        drain();

        // zero is the missing code, tightest missing rate
        load_settings(8'd0, 16'd0, HALF_FRAC, 22'd0, 22'd1, 17'd1);
        add_item(8'd0, 1'b0);
        add_item(8'd1, 1'b1);
        add_item(8'd7, 1'b1);
        play_stim();
        drain();

        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    mcode = MISSING_CODE_RST;
                    load_settings(mcode, 16'd0, HALF_FRAC, 22'd0, MAC_TOP, 17'd0);
                end
                1:
                begin
                    mcode = 8'hFF;
                    load_settings(mcode, 16'hFFFF, 16'hFFFF, 22'h3FFFFF, 22'h3FFFFF,
                                  17'h1FFFF);
                end
                default: random_settings(mcode);
            endcase
            queue_variants(100, mcode);
            // long receiver stall while items keep coming: the block must back up
            if (p == 3)
                long_hold = 400;
            play_stim();
            drain();
        end

        repeat (10) @(posedge clk);
        if (sb.mismatches == 0 && sb.decisions_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/gvqc_pkg.sv
design/gvqc_cfg.sv
design/gvqc_accum.sv
design/gvqc_decide.sv
design/genotype_variant_qc_filter_core.sv
sim/tb_genotype_variant_qc_filter_core.sv
